### src/stx_pkg.sv
package stx_pkg;

	localparam int RING_DEPTH = 64;
	localparam int RING_AW = $clog2(RING_DEPTH);
	localparam int CNT_W = 13;
	localparam int IDX_W = 12;
	localparam logic [CNT_W-1:0] MAX_TRANSFER = 13'd4096;
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_NUL = 8'h00;

	typedef enum logic [2:0] {
		OP_START_READ = 3'd0,
		OP_START_WRITE = 3'd1,
		OP_BYTE_RX = 3'd2,
		OP_TX_READY = 3'd3,
		OP_RING_POP = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_READ = 2'd1,
		MODE_WRITE = 2'd2
	} mode_t;

	// result fields known at accept time; the popped byte comes from the RAM later
	typedef struct packed {
		logic tx_valid;
		logic [7:0] tx_byte;
		logic store_valid;
		logic [IDX_W-1:0] store_index;
		logic [7:0] store_byte;
		logic pop_valid;
		logic done_event;
		logic tx_irq_disable;
		logic [1:0] transfer_status;
		logic ring_is_full;
		logic [CNT_W-1:0] bytes_done;
	} res_t;

	typedef struct packed {
		logic we;
		logic [RING_AW-1:0] waddr;
		logic [7:0] wdata;
		logic re;
		logic [RING_AW-1:0] raddr;
	} ram_req_t;

	function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] i);
		logic [RING_AW-1:0] r;
		if (i == RING_AW'(RING_DEPTH - 1)) r = '0;
		else r = i + 1'b1;
		return r;
	endfunction

endpackage

### src/stx_ram.sv
module stx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end

endmodule

### src/stx_ctrl.sv
module stx_ctrl
	import stx_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic port_open,
	input logic accept,
	input logic [2:0] op,
	input logic [7:0] data_byte,
	input logic [CNT_W-1:0] req_count,
	output res_t res,
	output ram_req_t ram_req
);

	logic port_open_q;
	mode_t mode_q, mode_n;
	logic [CNT_W-1:0] remaining_q, remaining_n;
	logic [CNT_W-1:0] transferred_q, transferred_n;
	logic [RING_AW-1:0] head_q, head_n, tail_q, tail_n;
	logic full_q, full_n;
	logic [CNT_W-1:0] count_sat;
	logic [CNT_W-1:0] rem_dec;
	logic [RING_AW-1:0] head_inc;

	assign count_sat = (req_count > MAX_TRANSFER) ? MAX_TRANSFER : req_count;
	assign rem_dec = (remaining_q != '0) ? remaining_q - 1'b1 : remaining_q;
	assign head_inc = ring_next(head_q);

	always_comb begin
		mode_n = mode_q;
		remaining_n = remaining_q;
		transferred_n = transferred_q;
		head_n = head_q;
		tail_n = tail_q;
		full_n = full_q;
		res = '0;
		ram_req = '0;
		ram_req.waddr = head_q;
		ram_req.wdata = data_byte;
		ram_req.raddr = tail_q;
		if (port_open_q) begin
			unique case (op)
				OP_START_READ, OP_START_WRITE: begin
					if (mode_q == MODE_IDLE) begin
						transferred_n = '0;
						remaining_n = count_sat;
						if (op == OP_START_WRITE) mode_n = MODE_WRITE;
						else if (count_sat == '0) res.done_event = 1'b1;
						else mode_n = MODE_READ;
					end
				end
				OP_BYTE_RX: begin
					if (mode_q == MODE_READ) begin
						res.store_valid = 1'b1;
						res.store_index = transferred_q[IDX_W-1:0];
						res.store_byte = data_byte;
						transferred_n = transferred_q + 1'b1;
						remaining_n = rem_dec;
						if (rem_dec == '0 || data_byte == CHAR_CR) begin
							mode_n = MODE_IDLE;
							res.done_event = 1'b1;
						end
					end else if (!full_q) begin
						ram_req.we = 1'b1;
						head_n = head_inc;
						if (head_inc == tail_q) full_n = 1'b1;
					end
				end
				OP_TX_READY: begin
					if (mode_q == MODE_WRITE) begin
						if (remaining_q == '0) begin
							res.tx_irq_disable = 1'b1;
							res.done_event = 1'b1;
							mode_n = MODE_IDLE;
						end else if (data_byte != CHAR_NUL) begin
							res.tx_valid = 1'b1;
							res.tx_byte = data_byte;
							remaining_n = rem_dec;
							transferred_n = transferred_q + 1'b1;
							if (rem_dec == '0) begin
								res.tx_irq_disable = 1'b1;
								res.done_event = 1'b1;
								mode_n = MODE_IDLE;
							end
						end
					end
				end
				OP_RING_POP: begin
					if (full_q || head_q != tail_q) begin
						res.pop_valid = 1'b1;
						ram_req.re = 1'b1;
						tail_n = ring_next(tail_q);
						full_n = 1'b0;
					end
				end
				default: ;
			endcase
		end
		res.transfer_status = mode_n;
		res.ring_is_full = full_n;
		res.bytes_done = transferred_n;
		// only an accepted request touches the ring
		ram_req.we = ram_req.we & accept;
		ram_req.re = ram_req.re & accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_open_q <= 1'b0;
			mode_q <= MODE_IDLE;
			remaining_q <= '0;
			transferred_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			full_q <= 1'b0;
		end else begin
			if (cfg_we) port_open_q <= port_open;
			if (accept) begin
				mode_q <= mode_n;
				remaining_q <= remaining_n;
				transferred_q <= transferred_n;
				head_q <= head_n;
				tail_q <= tail_n;
				full_q <= full_n;
			end
		end
	end

endmodule

### src/serial_transfer_engine.sv
// A result is loaded into stage 1 (res_s1) at its accept edge and then moves into the
// output register (res_s2) when that register is empty or being taken by the consumer.
// Throughput: one request per cycle; in_ready drops only when both the ring read
// stage and the output register hold results that the consumer has not taken.
// Reset (arst_n, async, active low): port closed, mode idle, counts and ring pointers
// zero, pipeline empty. Ring contents are not cleared; a pop only reads written entries.
module serial_transfer_engine
	import stx_pkg::*;
(
	input logic clk,
	input logic arst_n,
	// configuration: port_open written when cfg_we is high
	input logic cfg_we,
	input logic port_open,
	// request channel
	input logic in_valid,
	output logic in_ready,
	input logic [2:0] op,
	input logic [7:0] data_byte,
	input logic [CNT_W-1:0] req_count,
	// result channel
	output logic out_valid,
	input logic out_ready,
	output logic tx_valid,
	output logic [7:0] tx_byte,
	output logic store_valid,
	output logic [IDX_W-1:0] store_index,
	output logic [7:0] store_byte,
	output logic pop_valid,
	output logic [7:0] pop_byte,
	output logic done_event,
	output logic tx_irq_disable,
	output logic [1:0] transfer_status,
	output logic ring_is_full,
	output logic [CNT_W-1:0] bytes_done
);

	logic accept;
	res_t res;
	ram_req_t ram_req;
	logic [7:0] ring_rdata;

	// stage 1: state updated, ring read in flight
	logic valid_s1;
	res_t res_s1;
	// stage 2: output register
	logic valid_s2;
	res_t res_s2;
	logic [7:0] pop_byte_s2;
	logic adv_s2;

	assign adv_s2 = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s2;
	assign accept = in_valid && in_ready;

	// Control state lives in flops inside the controller and is updated at the
	// accept edge, so the next request sees it without any forwarding. The ring
	// bytes live in the RAM: a push writes at head in the accept cycle, and a pop
	// reads at tail in the accept cycle. A pop that follows a push of the same
	// entry reads after the write has landed.
	stx_ctrl u_ctrl (
		.clk (clk),
		.arst_n (arst_n),
		.cfg_we (cfg_we),
		.port_open (port_open),
		.accept (accept),
		.op (op),
		.data_byte (data_byte),
		.req_count (req_count),
		.res (res),
		.ram_req (ram_req)
	);

	stx_ram #(
		.WIDTH (8),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk (clk),
		.we (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ring_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s2) valid_s2 <= valid_s1;
			if (in_ready) valid_s1 <= in_valid;
		end
	end

	// RAM read data holds while stage 1 waits: a new read needs a new accept,
	// which only happens as stage 1 moves on.
	always_ff @(posedge clk) begin
		if (accept) res_s1 <= res;
		if (valid_s1 && adv_s2) begin
			res_s2 <= res_s1;
			pop_byte_s2 <= res_s1.pop_valid ? ring_rdata : 8'h00;
		end
	end

	assign out_valid = valid_s2;
	assign tx_valid = res_s2.tx_valid;
	assign tx_byte = res_s2.tx_byte;
	assign store_valid = res_s2.store_valid;
	assign store_index = res_s2.store_index;
	assign store_byte = res_s2.store_byte;
	assign pop_valid = res_s2.pop_valid;
	assign pop_byte = pop_byte_s2;
	assign done_event = res_s2.done_event;
	assign tx_irq_disable = res_s2.tx_irq_disable;
	assign transfer_status = res_s2.transfer_status;
	assign ring_is_full = res_s2.ring_is_full;
	assign bytes_done = res_s2.bytes_done;

endmodule

### src/stx_checker.sv
module stx_checker
	import stx_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic tx_valid,
	input logic [7:0] tx_byte,
	input logic store_valid,
	input logic pop_valid,
	input logic [7:0] pop_byte,
	input logic done_event,
	input logic tx_irq_disable,
	input logic [1:0] transfer_status
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(pop_byte))
		else $error("result changed while stalled");

	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones({tx_valid, store_valid, pop_valid}) <= 1)
		else $error("more than one data event in a result");

	a_irq_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_irq_disable |-> done_event && transfer_status == MODE_IDLE)
		else $error("irq disable without write completion");

	a_tx_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_valid |-> transfer_status == MODE_WRITE || tx_irq_disable)
		else $error("byte sent outside a write");

endmodule

bind serial_transfer_engine stx_checker u_stx_checker (
	.clk (clk),
	.arst_n (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.tx_valid (tx_valid),
	.tx_byte (tx_byte),
	.store_valid (store_valid),
	.pop_valid (pop_valid),
	.pop_byte (pop_byte),
	.done_event (done_event),
	.tx_irq_disable (tx_irq_disable),
	.transfer_status (transfer_status)
);

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import stx_pkg::*;

	// op codes that the block ignores
	localparam logic [2:0] OP_SPARE_A = 3'd5;
	localparam logic [2:0] OP_SPARE_B = 3'd6;
	localparam logic [2:0] OP_SPARE_C = 3'd7;
	localparam logic [2:0] OP_LAST = 3'd7;
	localparam logic [CNT_W-1:0] CNT_ALL_ONES = {CNT_W{1'b1}};
	localparam int ITEM_GOAL = 1750;

	typedef struct packed {
		logic [2:0] code;
		logic [7:0] data;
		logic [CNT_W-1:0] count;
	} serial_req_t;

	typedef struct packed {
		logic tx_valid;
		logic [7:0] tx_byte;
		logic store_valid;
		logic [IDX_W-1:0] store_index;
		logic [7:0] store_byte;
		logic pop_valid;
		logic [7:0] pop_byte;
		logic done_event;
		logic tx_irq_disable;
		logic [1:0] transfer_status;
		logic ring_is_full;
		logic [CNT_W-1:0] bytes_done;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic port_open = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] op = '0;
	logic [7:0] data_byte = '0;
	logic [CNT_W-1:0] req_count = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic tx_valid;
	logic [7:0] tx_byte;
	logic store_valid;
	logic [IDX_W-1:0] store_index;
	logic [7:0] store_byte;
	logic pop_valid;
	logic [7:0] pop_byte;
	logic done_event;
	logic tx_irq_disable;
	logic [1:0] transfer_status;
	logic ring_is_full;
	logic [CNT_W-1:0] bytes_done;

	serial_transfer_engine u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.port_open(port_open),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.data_byte(data_byte),
		.req_count(req_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.tx_valid(tx_valid),
		.tx_byte(tx_byte),
		.store_valid(store_valid),
		.store_index(store_index),
		.store_byte(store_byte),
		.pop_valid(pop_valid),
		.pop_byte(pop_byte),
		.done_event(done_event),
		.tx_irq_disable(tx_irq_disable),
		.transfer_status(transfer_status),
		.ring_is_full(ring_is_full),
		.bytes_done(bytes_done)
	);

	always #2 clk = ~clk;

	// engine state as the bench sees it
	bit port_is_open = 1'b0;
	mode_t cur_mode = MODE_IDLE;
	logic [CNT_W-1:0] left_cnt = '0;
	logic [CNT_W-1:0] moved_cnt = '0;
	logic [7:0] ring_mem [RING_DEPTH] = '{default: 8'h00};
	logic [RING_AW-1:0] wr_ptr = '0;
	logic [RING_AW-1:0] rd_ptr = '0;
	bit ring_full = 1'b0;

	serial_req_t pending_q[$];
	outcome_t awaited_q[$];
	int unsigned errors = 0;
	int unsigned made = 0;
	bit calm = 1'b0;
	bit req_taken = 1'b0;
	int unsigned send_gap = 0;
	int unsigned stall_left = 0;

	function automatic logic [RING_AW-1:0] ring_adv(logic [RING_AW-1:0] p);
		return (p == RING_AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// one request against the engine state; returns the result it must produce
	function automatic outcome_t serial_engine_step(serial_req_t r);
		outcome_t o;
		logic [CNT_W-1:0] cnt;
		bit stalled;
		o = '0;
		stalled = 1'b0;
		cnt = (r.count > MAX_TRANSFER) ? MAX_TRANSFER : r.count;
		if (port_is_open) begin
			if ((r.code == OP_START_READ || r.code == OP_START_WRITE) && cur_mode == MODE_IDLE) begin
				moved_cnt = '0;
				left_cnt = cnt;
				if (r.code == OP_START_READ) begin
					if (cnt == 0) o.done_event = 1'b1;
					else cur_mode = MODE_READ;
				end else begin
					cur_mode = MODE_WRITE;
				end
			end else if (r.code == OP_BYTE_RX) begin
				if (cur_mode == MODE_READ) begin
					o.store_valid = 1'b1;
					o.store_index = moved_cnt[IDX_W-1:0];
					o.store_byte = r.data;
					moved_cnt++;
					if (left_cnt != 0) left_cnt--;
					if (left_cnt == 0 || r.data == CHAR_CR) begin
						cur_mode = MODE_IDLE;
						o.done_event = 1'b1;
					end
				end else if (!ring_full) begin
					ring_mem[wr_ptr] = r.data;
					wr_ptr = ring_adv(wr_ptr);
					if (wr_ptr == rd_ptr) ring_full = 1'b1;
				end
			end else if (r.code == OP_TX_READY && cur_mode == MODE_WRITE) begin
				if (left_cnt != 0) begin
					if (r.data != CHAR_NUL) begin
						o.tx_valid = 1'b1;
						o.tx_byte = r.data;
						left_cnt--;
						moved_cnt++;
					end else begin
						stalled = 1'b1;
					end
				end
				if (!stalled && left_cnt == 0) begin
					o.tx_irq_disable = 1'b1;
					o.done_event = 1'b1;
					cur_mode = MODE_IDLE;
				end
			end else if (r.code == OP_RING_POP) begin
				if (ring_full || wr_ptr != rd_ptr) begin
					o.pop_valid = 1'b1;
					o.pop_byte = ring_mem[rd_ptr];
					rd_ptr = ring_adv(rd_ptr);
					ring_full = 1'b0;
				end
			end
		end
		o.transfer_status = cur_mode;
		o.ring_is_full = ring_full;
		o.bytes_done = moved_cnt;
		return o;
	endfunction

	function automatic void check_field(string name, logic [CNT_W-1:0] want,
			logic [CNT_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	function automatic void push_req(logic [2:0] code, logic [7:0] data,
			logic [CNT_W-1:0] count);
		serial_req_t r;
		r.code = code;
		r.data = data;
		r.count = count;
		pending_q.push_back(r);
		if (port_is_open) made++;
	endfunction

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// read request, ended by its count or an early CR; sometimes cut short
	function automatic void add_read_seq();
		int unsigned sel, nb, cr_at, cut;
		logic [CNT_W-1:0] cnt;
		logic [7:0] b;
		sel = $urandom_range(0, 15);
		if (sel < 11) cnt = CNT_W'($urandom_range(1, 24));
		else if (sel < 13) cnt = CNT_W'($urandom_range(25, 300));
		else if (sel < 14) cnt = '0;
		else cnt = CNT_W'($urandom_range(int'(MAX_TRANSFER) + 1, int'(CNT_ALL_ONES)));
		push_req(OP_START_READ, any_byte(), cnt);
		nb = (cnt > MAX_TRANSFER) ? $urandom_range(1, 40) : int'(cnt);
		if (nb == 0) return;
		cr_at = (cnt > MAX_TRANSFER || $urandom_range(0, 2) == 0) ?
			$urandom_range(0, nb - 1) : nb;
		cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, nb - 1) : nb;
		for (int unsigned i = 0; i < nb; i++) begin
			b = (i == cr_at) ? CHAR_CR : any_byte();
			push_req(OP_BYTE_RX, b, CNT_W'($urandom_range(0, 8191)));
			if (i == cr_at || i == cut) break;
		end
	endfunction

	// write request with NUL stalls mixed in; sometimes cut short
	function automatic void add_write_seq();
		int unsigned cnt, sent, cut, steps;
		cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
		cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, cnt) : cnt + 1;
		push_req(OP_START_WRITE, any_byte(), CNT_W'(cnt));
		if (cnt == 0) begin
			push_req(OP_TX_READY, any_byte(), '0);
			return;
		end
		sent = 0;
		steps = 0;
		while (sent < cnt && steps != cut) begin
			if ($urandom_range(0, 5) == 0) begin
				push_req(OP_TX_READY, CHAR_NUL, '0);
			end else begin
				push_req(OP_TX_READY, 8'($urandom_range(1, 255)), '0);
				sent++;
			end
			steps++;
		end
	endfunction

	// fill and drain the receive ring, in bursts or interleaved
	function automatic void add_ring_seq();
		int unsigned n;
		if ($urandom_range(0, 1) == 0) begin
			n = $urandom_range(1, 72);
			repeat (n) push_req(OP_BYTE_RX, any_byte(), '0);
			n = $urandom_range(1, 72);
			repeat (n) push_req(OP_RING_POP, any_byte(), '0);
		end else begin
			n = $urandom_range(4, 40);
			repeat (n) begin
				if ($urandom_range(0, 1) == 0) push_req(OP_BYTE_RX, any_byte(), '0);
				else push_req(OP_RING_POP, any_byte(), '0);
			end
		end
	endfunction

	function automatic void add_noise();
		int unsigned n;
		logic [CNT_W-1:0] cnt;
		n = $urandom_range(1, 6);
		repeat (n) begin
			cnt = ($urandom_range(0, 31) == 0) ? CNT_W'($urandom_range(0, 8191)) :
				CNT_W'($urandom_range(0, 31));
			push_req(3'($urandom_range(0, OP_LAST)), any_byte(), cnt);
		end
	endfunction

	// wait until every queued request is sent and answered, then let the pipe settle
	task automatic drain();
		do begin
			@(negedge clk);
			#1;
		end while (pending_q.size() != 0 || in_valid || awaited_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_port(bit v);
		@(negedge clk);
		cfg_we = 1'b1;
		port_open = v;
		port_is_open = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// finish whatever request is still open so the next phase starts from idle
	task automatic close_request();
		if (cur_mode == MODE_READ) begin
			push_req(OP_BYTE_RX, CHAR_CR, '0);
		end else if (cur_mode == MODE_WRITE) begin
			if (left_cnt == 0) push_req(OP_TX_READY, any_byte(), '0);
			for (int unsigned i = 0; i < left_cnt; i++)
				push_req(OP_TX_READY, 8'($urandom_range(1, 255)), '0);
		end
		drain();
	endtask

	// request driver: payload held until the handshake completes
	always @(posedge clk) req_taken <= in_valid && in_ready;

	always @(negedge clk) begin : drive_requests
		serial_req_t nxt;
		if (arst_n && (!in_valid || req_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_q.size() != 0) begin
				nxt = pending_q.pop_front();
				in_valid <= 1'b1;
				op <= nxt.code;
				data_byte <= nxt.data;
				req_count <= nxt.count;
				send_gap = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
		end
	end

	// monitor: check results in order, predict each accepted request
	always @(posedge clk) begin : watch_results
		outcome_t want;
		serial_req_t seen;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (awaited_q.size() == 0) begin
					$error("result with no request outstanding");
					errors++;
				end else begin
					want = awaited_q.pop_front();
					check_field("tx_valid", want.tx_valid, tx_valid);
					check_field("tx_byte", want.tx_byte, tx_byte);
					check_field("store_valid", want.store_valid, store_valid);
					check_field("store_index", want.store_index, store_index);
					check_field("store_byte", want.store_byte, store_byte);
					check_field("pop_valid", want.pop_valid, pop_valid);
					check_field("pop_byte", want.pop_byte, pop_byte);
					check_field("done_event", want.done_event, done_event);
					check_field("tx_irq_disable", want.tx_irq_disable, tx_irq_disable);
					check_field("transfer_status", want.transfer_status, transfer_status);
					check_field("ring_is_full", want.ring_is_full, ring_is_full);
					check_field("bytes_done", want.bytes_done, bytes_done);
				end
			end
			if (in_valid && in_ready) begin
				seen.code = op;
				seen.data = data_byte;
				seen.count = req_count;
				awaited_q.push_back(serial_engine_step(seen));
			end
		end
	end

	initial begin : stimulus
		int unsigned phase, sel;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// closed port: everything ignored
		set_port(1'b0);
		push_req(OP_START_READ, 8'h00, 13'd3);
		push_req(OP_BYTE_RX, 8'h5A, '0);
		push_req(OP_RING_POP, 8'h00, '0);
		drain();

		set_port(1'b1);
		// read ended by count, starting at byte index zero
		push_req(OP_START_READ, 8'h00, 13'd3);
		push_req(OP_BYTE_RX, 8'hFF, '0);
		push_req(OP_BYTE_RX, 8'h00, '0);
		push_req(OP_BYTE_RX, 8'h41, '0);
		// zero-length read completes at once
		push_req(OP_START_READ, 8'h00, '0);
		// oversized read, a start while busy, then CR ends it
		push_req(OP_START_READ, 8'h00, CNT_ALL_ONES);
		push_req(OP_START_WRITE, 8'h00, 13'd5);
		push_req(OP_BYTE_RX, 8'h55, '0);
		push_req(OP_BYTE_RX, CHAR_CR, '0);
		// ring while idle, then pop past empty
		push_req(OP_BYTE_RX, 8'hA5, '0);
		push_req(OP_RING_POP, 8'h00, '0);
		push_req(OP_RING_POP, 8'h00, '0);
		// transmit ready with no write open
		push_req(OP_TX_READY, 8'h33, '0);
		// write with a NUL stall
		push_req(OP_START_WRITE, 8'h00, 13'd2);
		push_req(OP_TX_READY, CHAR_NUL, '0);
		push_req(OP_TX_READY, 8'h80, '0);
		push_req(OP_TX_READY, 8'h7F, '0);
		// zero-length write finishes on the next transmit ready
		push_req(OP_START_WRITE, 8'h00, '0);
		push_req(OP_TX_READY, 8'hFF, '0);
		// unused op codes
		push_req(OP_SPARE_A, 8'hFF, CNT_ALL_ONES);
		push_req(OP_SPARE_B, 8'h00, '0);
		push_req(OP_SPARE_C, 8'hFF, CNT_ALL_ONES);
		drain();

		phase = 0;
		made = 0;
		while (made < ITEM_GOAL) begin
			phase++;
			calm = ($urandom_range(0, 5) == 0);
			if (phase % 7 == 3) begin
				// leave a read open across a closed spell
				push_req(OP_START_READ, any_byte(), CNT_W'($urandom_range(2, 20)));
				drain();
				set_port(1'b0);
			end else if (!port_is_open) begin
				set_port(1'b1);
			end
			repeat (6) begin
				sel = $urandom_range(0, 19);
				if (sel < 6) add_read_seq();
				else if (sel < 12) add_write_seq();
				else if (sel < 17) add_ring_seq();
				else add_noise();
			end
			drain();
			if (port_is_open && cur_mode != MODE_IDLE) close_request();
		end

		drain();
		repeat (8) @(negedge clk);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
